// ----- design/sek_pkg.sv -----
// Shared types, constants and arithmetic helpers for the SE kernel element.
package sek_pkg;

  localparam int MAX_DIMS_DEF = 64;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [47:0] W_CAP = 48'h8000_0000_0000;
  localparam logic [29:0] ZERO30 = 30'd0;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic [1:0] REG_LOG_LENGTH = 2'd0;
  localparam logic [1:0] REG_LOG_SIGNAL = 2'd1;
  localparam logic [1:0] REG_LOG_NOISE  = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = xin;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (int n = 0; n < 32; n++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [511:0] pow2_table();
    logic [511:0] tab;
    logic [63:0] c;
    tab = '0;
    c = 64'h8000_0000;
    for (int i = 0; i < 16; i++) begin
      c = isqrt64(c << 30);
      tab[i*32 +: 32] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [511:0] POW2_TAB = pow2_table();

  // h * 2 * log2(e), Q4.12 in, Q16 out, floor rounding
  function automatic logic signed [22:0] twice_log2(input logic signed [16:0] h);
    logic signed [43:0] p;
    p = $signed({h, 1'b0}) * $signed({1'b0, LOG2E_Q24});
    return p[42:20];
  endfunction

  function automatic logic [31:0] exp2_q16(input logic signed [32:0] vi,
                                            input logic [31:0] m);
    logic signed [33:0] rs;
    logic [31:0] res;
    rs = 34'sd14 - {vi[32], vi};
    if (vi >= 33'sd16) res = 32'hFFFF_FFFF;
    else if (vi >= 33'sd14) res = m << vi[0];
    else if (rs >= 34'sd32) res = 32'd0;
    else res = m >> rs[4:0];
    return res;
  endfunction

endpackage

// ----- design/se_kernel_element.sv -----
// Top level of the squared-exponential kernel element.
// Usage: stream the coordinates of a point pair on the input channel, one
// coordinate pair per transfer, with last_dim set on the final one and
// same_point set there for a diagonal entry. The input channel takes one
// transfer per cycle; it stalls only while the two-entry pair queue is full.
// Each finished pair produces one kernel_value transfer on the output channel.
// The sequencer takes one pair at a time, as the shared 32x32 multiplier
// runs three sixteen-step 2^x evaluations per pair; accumulation of later
// pairs goes on meanwhile. The result waits in an output register while
// out_stall is high, and the sequencer holds its next result until that
// register frees up. Hyperparameters are written over the APB port at 0x0,
// 0x4, 0x8; the user must write them only while idle, as the block does not
// enforce it. Synchronous reset clears the accumulator, queue, sequencer,
// output valid and the hyperparameters to zero.
module se_kernel_element #(
  parameter int MAX_DIMS = sek_pkg::MAX_DIMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coord_a,
  input  logic signed [15:0] coord_b,
  input  logic               same_point,
  input  logic               last_dim,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        kernel_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int DW = $clog2(MAX_DIMS) + 33;

  logic signed [15:0] log_length_scale;
  logic signed [15:0] log_signal_scale;
  logic signed [15:0] log_noise_scale;
  logic accept;
  logic push;
  logic pop;
  logic [DW:0] push_data;
  logic [DW:0] q_data;
  sek_pkg::fifo_status_t fifo_st;
  logic out_free;
  logic done;
  logic [31:0] result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_length_scale <= '0;
      log_signal_scale <= '0;
      log_noise_scale <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        sek_pkg::REG_LOG_LENGTH: log_length_scale <= pwdata[15:0];
        sek_pkg::REG_LOG_SIGNAL: log_signal_scale <= pwdata[15:0];
        sek_pkg::REG_LOG_NOISE:  log_noise_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sek_pkg::REG_LOG_LENGTH: prdata = {16'd0, log_length_scale};
      sek_pkg::REG_LOG_SIGNAL: prdata = {16'd0, log_signal_scale};
      sek_pkg::REG_LOG_NOISE:  prdata = {16'd0, log_noise_scale};
      default: prdata = 32'd0;
    endcase
  end

  assign in_stall = fifo_st.full;
  assign accept = in_valid && !in_stall;

  sek_front #(.MAX_DIMS(MAX_DIMS), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .coord_a(coord_a), .coord_b(coord_b),
    .same_point(same_point), .last_dim(last_dim), .push(push), .push_data(push_data)
  );

  sek_fifo #(.WIDTH(DW + 1)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(push_data), .pop(pop),
    .rdata(q_data), .status(fifo_st)
  );

  sek_back #(.MAX_DIMS(MAX_DIMS), .DW(DW)) u_back (
    .clk(clk), .rst(rst), .q_avail(!fifo_st.empty), .q_data(q_data), .pop(pop),
    .log_length_scale(log_length_scale), .log_signal_scale(log_signal_scale),
    .log_noise_scale(log_noise_scale), .out_free(out_free), .done(done),
    .result(result)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) kernel_value <= result;
  end

  a_fifo_status: assert property (@(posedge clk) disable iff (rst)
    !(fifo_st.full && fifo_st.empty))
    else $error("queue reports full and empty together");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled transfer");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_st.full)
    else $error("queue push while full");
endmodule

// ----- design/sek_fifo.sv -----
// Two-entry queue between the accumulate front and the exponent back.
module sek_fifo #(
  parameter int WIDTH = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output sek_pkg::fifo_status_t status
);
  logic [WIDTH-1:0] mem [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata = mem[rptr];
  assign status.full = (count == 2'd2);
  assign status.empty = (count == 2'd0);
endmodule

// ----- design/sek_front.sv -----
// Input side: saturating sum of squared differences, one item per cycle on accept.
module sek_front #(
  parameter int MAX_DIMS = sek_pkg::MAX_DIMS_DEF,
  parameter int DW = $clog2(MAX_DIMS) + 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic signed [15:0] coord_a,
  input  logic signed [15:0] coord_b,
  input  logic               same_point,
  input  logic               last_dim,
  output logic               push,
  output logic [DW:0]        push_data
);
  localparam logic [DW:0] CAP = (DW+1)'(MAX_DIMS) << 32;

  logic [DW-1:0] acc;
  logic signed [16:0] diff;
  logic signed [33:0] sq;
  logic [DW:0] sum;
  logic [DW-1:0] acc_next;

  always_comb begin
    diff = 17'(coord_a) - 17'(coord_b);
    sq = diff * diff;
    sum = {1'b0, acc} + (DW+1)'(sq[31:0]);
    acc_next = (sum >= CAP) ? CAP[DW-1:0] : sum[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) acc <= '0;
    else if (accept) acc <= last_dim ? '0 : acc_next;
  end

  assign push = accept && last_dim;
  assign push_data = {same_point, acc_next};
endmodule

// ----- design/sek_back.sv -----
// Exponent sequencer: one shared Q30 multiplier walks the 2^x steps; scaling has its own.
module sek_back #(
  parameter int MAX_DIMS = sek_pkg::MAX_DIMS_DEF,
  parameter int DW = $clog2(MAX_DIMS) + 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_avail,
  input  logic [DW:0]        q_data,
  output logic               pop,
  input  logic signed [15:0] log_length_scale,
  input  logic signed [15:0] log_signal_scale,
  input  logic signed [15:0] log_noise_scale,
  input  logic               out_free,
  output logic               done,
  output logic [31:0]        result
);
  localparam int QW = DW + 18;

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001, S_U  = 13'h0002, S_P1 = 13'h0004, S_K  = 13'h0008,
    S_Q    = 13'h0010, S_W  = 13'h0020, S_V  = 13'h0040, S_P2 = 13'h0080,
    S_E1   = 13'h0100, S_N  = 13'h0200, S_P3 = 13'h0400, S_E2 = 13'h0800,
    S_DONE = 13'h1000
  } state_t;

  state_t state, state_next;
  logic [DW-1:0] acc;
  logic same;
  logic signed [22:0] u;
  logic [31:0] r;
  logic [15:0] f;
  logic [3:0] cnt;
  logic [17:0] k;
  logic [QW-1:0] q;
  logic [47:0] w;
  logic signed [32:0] vi;
  logic [31:0] term1;

  logic [63:0] step_prod;
  logic [31:0] coef;
  logic [56:0] kprod;
  logic signed [7:0] sh;
  logic [7:0] nsh;
  logic [63:0] q64;
  logic [63:0] wcalc;
  logic signed [22:0] tl_len;
  logic signed [22:0] tl_sig;
  logic signed [22:0] tl_noise;
  logic signed [48:0] v;
  logic [31:0] term2;
  logic [32:0] sum;

  always_comb begin
    coef = sek_pkg::POW2_TAB[{cnt, 5'd0} +: 32];
    step_prod = r * coef;
    kprod = r * sek_pkg::LOG2E_Q24;
    sh = 8'($signed(u[22:16])) - 8'sd17;
    nsh = -sh;
    q64 = 64'(q);
    if (sh >= 0) begin
      if (q64 > (64'(sek_pkg::W_CAP) >> sh[5:0])) wcalc = 64'(sek_pkg::W_CAP);
      else wcalc = q64 << sh[5:0];
    end else begin
      wcalc = (nsh >= 8'd64) ? 64'd0 : (q64 >> nsh[5:0]);
    end
    if (wcalc > 64'(sek_pkg::W_CAP)) wcalc = 64'(sek_pkg::W_CAP);
    tl_len = sek_pkg::twice_log2(-17'(log_length_scale));
    tl_sig = sek_pkg::twice_log2(17'(log_signal_scale));
    tl_noise = sek_pkg::twice_log2(17'(log_noise_scale));
    v = 49'(tl_sig) - $signed({1'b0, w});
    term2 = same ? sek_pkg::exp2_q16(vi, r) : 32'd0;
    sum = {1'b0, term1} + {1'b0, term2};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_avail) state_next = S_U;
      S_U:    state_next = S_P1;
      S_P1:   if (cnt == 4'd15) state_next = S_K;
      S_K:    state_next = S_Q;
      S_Q:    state_next = S_W;
      S_W:    state_next = S_V;
      S_V:    state_next = S_P2;
      S_P2:   if (cnt == 4'd15) state_next = S_E1;
      S_E1:   state_next = S_N;
      S_N:    state_next = S_P3;
      S_P3:   if (cnt == 4'd15) state_next = S_E2;
      S_E2:   state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        acc <= q_data[DW-1:0];
        same <= q_data[DW];
      end
      S_U: begin
        u <= tl_len;
        f <= tl_len[15:0];
        r <= sek_pkg::ONE_Q30;
        cnt <= 4'd0;
      end
      S_P1, S_P2, S_P3: begin
        if (f[4'd15 - cnt]) r <= step_prod[61:30];
        cnt <= cnt + 4'd1;
      end
      S_K: k <= kprod[55:38];
      S_Q: q <= QW'(acc) * QW'(k);
      S_W: w <= wcalc[47:0];
      S_V: begin
        vi <= 33'(v[48:16]);
        f <= v[15:0];
        r <= sek_pkg::ONE_Q30;
        cnt <= 4'd0;
      end
      S_E1: term1 <= sek_pkg::exp2_q16(vi, r);
      S_N: begin
        vi <= 33'($signed(tl_noise[22:16]));
        f <= tl_noise[15:0];
        r <= sek_pkg::ONE_Q30;
        cnt <= 4'd0;
      end
      S_E2: result <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      default: ;
    endcase
  end

  assign pop = (state == S_IDLE) && q_avail;
  assign done = (state == S_DONE) && out_free;
endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the squared-exponential kernel element.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam longint unsigned DIST_CAP = 64'd64 << 32;
  localparam longint unsigned LOG2E = 64'd24204406;
  localparam longint unsigned DECAY_CAP = 64'd1 << 47;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] coord_a;
  logic signed [15:0] coord_b;
  logic same_point;
  logic last_dim;
  logic out_valid;
  logic out_stall;
  logic [31:0] kernel_value;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  se_kernel_element dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coord_a(coord_a), .coord_b(coord_b),
    .same_point(same_point), .last_dim(last_dim),
    .out_valid(out_valid), .out_stall(out_stall), .kernel_value(kernel_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  longint lell;
  longint lsf;
  longint lsn;
  longint unsigned dist_sum;
  logic [31:0] kernel_queue[$];

  int errors = 0;
  int coords_sent = 0;
  int pairs_checked = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  bit apb_busy = 0;
  bit no_idle = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // 2^(f/65536) as Q30
  function automatic longint unsigned frac_pow2(input logic [15:0] f);
    longint unsigned r;
    longint unsigned c;
    r = 64'd1 << 30;
    c = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) begin
      c = int_sqrt(c << 30);
      if (f[16-i]) r = (r * c) >> 30;
    end
    return r;
  endfunction

  function automatic longint log2_twice(input longint h);
    return (2 * h * longint'(LOG2E)) >>> 20;
  endfunction

  function automatic longint unsigned pow2_fixed(input longint v);
    longint vi;
    longint unsigned m;
    vi = v >>> 16;
    m = frac_pow2(v[15:0]);
    if (vi >= 16) return 64'hFFFF_FFFF;
    if (vi >= 14) return m << (vi - 14);
    if (14 - vi >= 32) return 0;
    return m >> (14 - vi);
  endfunction

  // Accumulate one coordinate; on the last one push the expected kernel value.
  task automatic predict_kernel(input logic signed [15:0] a, input logic signed [15:0] b,
                                input logic same, input logic last);
    longint diff;
    longint unsigned sq;
    longint u;
    longint ui;
    longint sh;
    longint w;
    longint unsigned k;
    longint unsigned q;
    longint unsigned sum;
    diff = longint'(a) - longint'(b);
    sq = diff * diff;
    dist_sum = (sq >= DIST_CAP - dist_sum) ? DIST_CAP : dist_sum + sq;
    if (!last) return;
    u = log2_twice(-lell);
    ui = u >>> 16;
    k = (frac_pow2(u[15:0]) * LOG2E) >> 38;
    q = dist_sum * k;
    sh = ui - 17;
    if (sh >= 0) begin
      if (sh > 47 || q > (DECAY_CAP >> sh)) w = DECAY_CAP;
      else w = q << sh;
    end else begin
      w = (-sh >= 64) ? 0 : longint'(q >> (-sh));
    end
    if (w > longint'(DECAY_CAP)) w = DECAY_CAP;
    sum = pow2_fixed(log2_twice(lsf) - w);
    if (same) sum += pow2_fixed(log2_twice(lsn));
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    kernel_queue.push_back(sum[31:0]);
    dist_sum = 0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_kernel(coord_a, coord_b, same_point, last_dim);
      coords_sent++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (kernel_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected kernel_value %h", kernel_value));
      end else begin
        if (kernel_value !== kernel_queue[0])
          report_mismatch($sformatf("kernel_value got %h want %h", kernel_value,
                                    kernel_queue[0]));
        void'(kernel_queue.pop_front());
        pairs_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || apb_busy || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall <= 0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_coord(input logic [15:0] a, input logic [15:0] b,
                            input logic same, input logic last);
    int gap;
    in_valid <= 1;
    coord_a <= a;
    coord_b <= b;
    same_point <= same;
    last_dim <= last;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    do @(posedge clk); while (kernel_queue.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    apb_busy = 1;
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    case (idx)
      sek_pkg::REG_LOG_LENGTH: lell = longint'($signed(data[15:0]));
      sek_pkg::REG_LOG_SIGNAL: lsf = longint'($signed(data[15:0]));
      sek_pkg::REG_LOG_NOISE: lsn = longint'($signed(data[15:0]));
      default: ;
    endcase
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    reg_writes++;
    @(posedge clk);
    apb_busy = 0;
  endtask

  task automatic set_hypers(input logic [15:0] l, input logic [15:0] s, input logic [15:0] z);
    write_reg(sek_pkg::REG_LOG_LENGTH, {16'($urandom), l});
    write_reg(sek_pkg::REG_LOG_SIGNAL, {16'($urandom), s});
    write_reg(sek_pkg::REG_LOG_NOISE, {16'($urandom), z});
  endtask

  task automatic send_pair(input int dims, input logic same, input int spread);
    logic [15:0] a;
    logic [15:0] d;
    logic s;
    for (int i = 0; i < dims; i++) begin
      a = 16'($urandom);
      d = 16'($urandom_range(0, 2 * spread) - spread);
      s = (i == dims - 1) ? same : 1'($urandom);
      if ($urandom_range(0, 3) == 0)
        send_coord(16'($urandom), 16'($urandom), s, i == dims - 1);
      else send_coord(a, a + d, s, i == dims - 1);
    end
  endtask

  task automatic test_directed();
    no_idle = 1;
    send_coord(16'h7FFF, 16'h8000, 1'b0, 1'b1);
    send_coord(16'h8000, 16'h7FFF, 1'b1, 1'b1);
    send_coord(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_coord(16'h0100, 16'h0000, 1'b1, 1'b0);
    send_coord(16'hFF00, 16'h0000, 1'b0, 1'b1);
    no_idle = 0;
    // accumulator saturation: more max-distance coordinates than MAX_DIMS
    for (int i = 0; i < 70; i++) send_coord(16'h7FFF, 16'h8000, 1'b1, i == 69);
    wait_idle();
  endtask

  task automatic test_hyper_extremes();
    logic [15:0] vals[5];
    vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hF000, 16'h1000};
    for (int i = 0; i < 5; i++) begin
      set_hypers(vals[i], vals[(i + 1) % 5], vals[(i + 3) % 5]);
      write_reg(REG_UNMAPPED, $urandom);
      send_coord(16'h0000, 16'h0000, 1'b1, 1'b1);
      send_coord(16'h0010, 16'h0000, 1'b0, 1'b1);
      send_pair(3, 1'b1, 4096);
      send_coord(16'h7FFF, 16'h8000, 1'b1, 1'b1);
      wait_idle();
    end
    // equal signal and noise terms well under the limit, summed without overflow
    set_hypers(16'h0000, 16'h2C00, 16'h2C00);
    send_coord(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_coord(16'h0000, 16'h0000, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_pairs();
    int dims;
    int start;
    start = coords_sent;
    while (coords_sent - start < 450) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        if ($urandom_range(0, 3) == 0)
          set_hypers(16'($urandom), 16'($urandom), 16'($urandom));
        else set_hypers(16'($urandom_range(0, 16383) - 8192),
                        16'($urandom_range(0, 16383) - 8192),
                        16'($urandom_range(0, 16383) - 8192));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      dims = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 66) : $urandom_range(1, 8);
      send_pair(dims, 1'($urandom), ($urandom_range(0, 1) == 0) ? 256 : 32767);
    end
    no_idle = 0;
    wait_idle();
  endtask

  initial begin
    lell = 0;
    lsf = 0;
    lsn = 0;
    dist_sum = 0;
    rst <= 1;
    in_valid <= 0;
    coord_a <= 0;
    coord_b <= 0;
    same_point <= 0;
    last_dim <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= 0;
    pwdata <= 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_hyper_extremes();
    test_random_pairs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d coordinate transfers, %0d kernel values, %0d register writes",
             coords_sent, pairs_checked, reg_writes);
    if (kernel_queue.size() != 0)
      report_mismatch($sformatf("%0d kernel values never arrived", kernel_queue.size()));
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sek_pkg.sv
design/sek_fifo.sv
design/sek_front.sv
design/sek_back.sv
design/se_kernel_element.sv
bench/testbench.sv
